// ===== src/crtmr_pkg.sv =====
// Shared constants, modulus tables and types for the CRT modular reduction pipeline.
package crtmr_pkg;

  localparam int NumModuli = 8;
  localparam int IdxW      = 3;
  localparam int ValW      = 64;
  localparam int ResW      = 32;
  localparam int FacW      = 6;
  localparam int NumStages = 5;

  localparam logic FUNC_MONT    = 1'b0;
  localparam logic FUNC_BARRETT = 1'b1;

  typedef logic [ResW-1:0] word_t;
  typedef logic [ValW-1:0] dword_t;
  typedef logic [FacW-1:0] fac_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic   mode;
    word_t  q;
    dword_t val;
  } item_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  function automatic word_t modulus_lut(input idx_t idx);
    word_t q;
    case (idx)
      3'd0:    q = 32'h1CF53113;
      3'd1:    q = 32'h19E8DB11;
      3'd2:    q = 32'h16DC850F;
      3'd3:    q = 32'h13D02F0D;
      3'd4:    q = 32'h10C3D90B;
      3'd5:    q = 32'h0DB78309;
      3'd6:    q = 32'h0AAB2D07;
      default: q = 32'h079ED705;
    endcase
    return q;
  endfunction

  function automatic word_t inverse_lut(input idx_t idx);
    word_t inv;
    case (idx)
      3'd0:    inv = 32'hD05A411B;
      3'd1:    inv = 32'h06FB75F1;
      3'd2:    inv = 32'h07E9C9EF;
      3'd3:    inv = 32'hF57037C5;
      3'd4:    inv = 32'hADB32AA3;
      3'd5:    inv = 32'hB7DAFB39;
      3'd6:    inv = 32'hEC62B0B7;
      default: inv = 32'h17BD5DCD;
    endcase
    return inv;
  endfunction

  function automatic fac_t factor_lut(input idx_t idx);
    fac_t f;
    case (idx)
      3'd0:    f = 6'd9;
      3'd1:    f = 6'd10;
      3'd2:    f = 6'd11;
      3'd3:    f = 6'd13;
      3'd4:    f = 6'd15;
      3'd5:    f = 6'd19;
      3'd6:    f = 6'd24;
      default: f = 6'd34;
    endcase
    return f;
  endfunction

endpackage

// ===== src/crt_modular_reduction.sv =====
// Top level: five-stage Montgomery / Barrett reduction pipeline over eight CRT moduli.
// Input acceptance reaches out_valid through five register stages,
// one each for table lookup, first multiply, second multiply, subtract and correction.
// Throughput: one item per cycle while out_stall is low; the two 32x32 multipliers set the stage depth.
// A stall holds each occupied stage with no empty stage after it; empty stages still fill, so bubbles are squeezed out.
// Reset (synchronous, rst_n low) clears all stage valid bits; payload registers keep data.
module crt_modular_reduction (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [crtmr_pkg::IdxW-1:0]    in_modulus_index,
  input  logic signed [crtmr_pkg::ValW-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [crtmr_pkg::ResW-1:0] out_residue
);

  logic [crtmr_pkg::NumStages-1:0] vld_r;
  logic [crtmr_pkg::NumStages-1:0] vld_nxt;
  crtmr_pkg::stage_en_t            en;

  crtmr_pkg::item_t  item_s1_r;
  crtmr_pkg::item_t  item_s1_nxt;
  crtmr_pkg::item_t  item_s2_r;
  crtmr_pkg::item_t  item_s3_r;
  crtmr_pkg::word_t  opnd_r;
  crtmr_pkg::word_t  opnd_nxt;
  crtmr_pkg::dword_t prod1;
  crtmr_pkg::dword_t prod2;
  crtmr_pkg::word_t  mul2_a;
  crtmr_pkg::word_t  residue;

  assign en.s5 = !vld_r[4] || !out_stall;
  assign en.s4 = !vld_r[3] || en.s5;
  assign en.s3 = !vld_r[2] || en.s4;
  assign en.s2 = !vld_r[1] || en.s3;
  assign en.s1 = !vld_r[0] || en.s2;

  assign in_stall = !en.s1;

  always_comb begin
    vld_nxt = vld_r;
    if (en.s1) vld_nxt[0] = in_valid;
    if (en.s2) vld_nxt[1] = vld_r[0];
    if (en.s3) vld_nxt[2] = vld_r[1];
    if (en.s4) vld_nxt[3] = vld_r[2];
    if (en.s5) vld_nxt[4] = vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    item_s1_nxt.mode = in_func;
    item_s1_nxt.q    = crtmr_pkg::modulus_lut(in_modulus_index);
    item_s1_nxt.val  = in_value;
    opnd_nxt = (in_func == crtmr_pkg::FUNC_BARRETT)
             ? crtmr_pkg::word_t'(crtmr_pkg::factor_lut(in_modulus_index))
             : crtmr_pkg::inverse_lut(in_modulus_index);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      item_s1_r <= item_s1_nxt;
      opnd_r    <= opnd_nxt;
    end
    if (en.s2) begin
      item_s2_r <= item_s1_r;
    end
    if (en.s3) begin
      item_s3_r <= item_s2_r;
    end
  end

  crtmr_mul_stage u_mul1 (
    .clk    (clk),
    .en     (en.s2),
    .a_i    (item_s1_r.val[crtmr_pkg::ResW-1:0]),
    .b_i    (opnd_r),
    .prod_o (prod1)
  );

  assign mul2_a = (item_s2_r.mode == crtmr_pkg::FUNC_BARRETT)
                ? prod1[crtmr_pkg::ValW-1:crtmr_pkg::ResW]
                : prod1[crtmr_pkg::ResW-1:0];

  crtmr_mul_stage u_mul2 (
    .clk    (clk),
    .en     (en.s3),
    .a_i    (mul2_a),
    .b_i    (item_s2_r.q),
    .prod_o (prod2)
  );

  crtmr_fix u_fix (
    .clk       (clk),
    .en_sub    (en.s4),
    .en_fix    (en.s5),
    .mode_i    (item_s3_r.mode),
    .q_i       (item_s3_r.q),
    .val_i     (item_s3_r.val),
    .prod_i    (prod2),
    .residue_o (residue)
  );

  assign out_valid   = vld_r[4];
  assign out_residue = $signed(residue);

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (vld_r == '1))
    else $error("input stalled while a stage is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_residue)))
    else $error("stalled result lost or changed");

  a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && out_stall && vld_r[3]) |=> vld_r[3])
    else $error("item dropped from subtract stage under stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && en.s5) |=> vld_r[4])
    else $error("item lost between subtract and correction stages");

endmodule

// ===== src/crtmr_mul_stage.sv =====
// Registered signed-by-unsigned 32x32 multiply stage giving the low 64 product bits.
module crtmr_mul_stage (
  input  logic                 clk,
  input  logic                 en,
  input  crtmr_pkg::word_t     a_i,
  input  crtmr_pkg::word_t     b_i,
  output crtmr_pkg::dword_t    prod_o
);

  logic signed [crtmr_pkg::ValW:0] full;
  crtmr_pkg::dword_t               prod_r;
  crtmr_pkg::dword_t               prod_nxt;

  assign full     = $signed(a_i) * $signed({1'b0, b_i});
  assign prod_nxt = full[crtmr_pkg::ValW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_o = prod_r;

endmodule

// ===== src/crtmr_fix.sv =====
// Final subtract and conditional modulus correction, two register stages.
module crtmr_fix (
  input  logic                 clk,
  input  logic                 en_sub,
  input  logic                 en_fix,
  input  logic                 mode_i,
  input  crtmr_pkg::word_t     q_i,
  input  crtmr_pkg::dword_t    val_i,
  input  crtmr_pkg::dword_t    prod_i,
  output crtmr_pkg::word_t     residue_o
);

  crtmr_pkg::dword_t diff;
  crtmr_pkg::word_t  r_r;
  crtmr_pkg::word_t  r_nxt;
  crtmr_pkg::word_t  q_r;
  crtmr_pkg::word_t  residue_r;
  crtmr_pkg::word_t  residue_nxt;

  assign diff  = val_i - prod_i;
  assign r_nxt = (mode_i == crtmr_pkg::FUNC_BARRETT) ? diff[crtmr_pkg::ResW-1:0]
                                                      : diff[crtmr_pkg::ValW-1:crtmr_pkg::ResW];

  assign residue_nxt = ($signed(r_r) >= $signed(q_r)) ? (r_r - q_r) : r_r;

  always_ff @(posedge clk) begin
    if (en_sub) begin
      r_r <= r_nxt;
      q_r <= q_i;
    end
    if (en_fix) begin
      residue_r <= residue_nxt;
    end
  end

  assign residue_o = residue_r;

endmodule
